// ===== hw/rtl/mqll_pkg.sv =====
`default_nettype none

package mqll_pkg;

    // Default sizes of the slot pool and of the queue table.
    localparam int ENTRIES_DEF = 64;
    localparam int QUEUES_DEF  = 8;

    // Fixed widths of the item fields.
    localparam int OP_W  = 2;
    localparam int QID_W = 3;
    localparam int ENT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_queue_linked_list_manager.sv =====
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// s_       | in        | s_valid / s_ready  | s_operation, s_queue_id, s_entry_index
// m_       | out       | m_valid / m_ready  | m_status, m_popped_entry
//
// Flow: one item at a time, s_ready high only in idle. Rejected item (bad opcode, queue or
// slot) ends in S_IDLE; append to an empty queue, pop or remove on an empty queue in S_QRD;
// other append in S_APP2; pop and remove of the head in S_POPW; other remove walks S_WALK,
// S_RM, S_RM2, a miss ends in S_WALK. Each walk step is one read of the link memory port.
// Reset: synchronous, active low; clears the sequencer, output valid and head/tail valid bits.
// Stalls: the result register holds while m_ready is low; a result that finds it full parks
// and holds s_ready low until it drains.
module multi_queue_linked_list_manager #(
    parameter int ENTRIES = mqll_pkg::ENTRIES_DEF,
    parameter int QUEUES  = mqll_pkg::QUEUES_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [mqll_pkg::OP_W-1:0]  s_operation,
    input  wire logic [mqll_pkg::QID_W-1:0] s_queue_id,
    input  wire logic [mqll_pkg::ENT_W-1:0] s_entry_index,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_status,
    output logic      [mqll_pkg::ENT_W-1:0] m_popped_entry
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);
    localparam logic [IW-1:0] LAST_STEP = IW'(ENTRIES - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // wait for an item, read the queue's head/tail
        S_QRD  = 8'b0000_0010,  // head/tail available, dispatch on the operation
        S_APP2 = 8'b0000_0100,  // second link write of an append
        S_POPW = 8'b0000_1000,  // link of the head available, unlink it
        S_WALK = 8'b0001_0000,  // one link per cycle along the queue
        S_RM   = 8'b0010_0000,  // link of the found slot available, bridge over it
        S_RM2  = 8'b0100_0000,  // clear the link of the removed slot
        S_DONE = 8'b1000_0000   // result parked, wait for the output register
    } state_t;

    state_t state_reg, state_next;

    // Item being worked on.
    mqll_pkg::op_t op_reg, op_next;
    logic [QW-1:0] q_reg, q_next;
    logic [LW-1:0] e_reg, e_next;

    // Snapshot of head/tail and walk pointers.
    logic [LW-1:0] hd_reg, hd_next;
    logic [LW-1:0] tl_reg, tl_next;
    logic [LW-1:0] pred_reg, pred_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [IW-1:0] steps_reg, steps_next;

    // Parked result and the output register.
    logic                      res_status_reg;
    logic [mqll_pkg::ENT_W-1:0] res_popped_reg;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_status_reg;
    logic [mqll_pkg::ENT_W-1:0] m_popped_reg;

    // Result produced this cycle.
    logic                      fin;
    logic                      fin_status;
    logic [mqll_pkg::ENT_W-1:0] fin_popped;
    logic                      out_free;
    logic                      out_load;

    // Memory ports.
    logic          qt_re, qt_we;
    logic [QW-1:0] qt_raddr, qt_waddr;
    logic [LW-1:0] qt_rd_head, qt_rd_tail, qt_wr_head, qt_wr_tail;
    logic          lk_re, lk_we;
    logic [IW-1:0] lk_raddr, lk_waddr;
    logic [LW-1:0] lk_rd_data, lk_wr_data;

    // Decode of the incoming item.
    logic in_q_ok, in_e_ok, in_op_ok, in_bad;
    logic qt_empty;
    logic lk_nil;

    mqll_queue_mem #(
        .QUEUES  (QUEUES),
        .ENTRIES (ENTRIES)
    ) u_queue_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (qt_re),
        .rd_addr (qt_raddr),
        .rd_head (qt_rd_head),
        .rd_tail (qt_rd_tail),
        .wr_en   (qt_we),
        .wr_addr (qt_waddr),
        .wr_head (qt_wr_head),
        .wr_tail (qt_wr_tail)
    );

    mqll_link_mem #(
        .ENTRIES (ENTRIES)
    ) u_link_mem (
        .aclk    (aclk),
        .rd_en   (lk_re),
        .rd_addr (lk_raddr),
        .rd_data (lk_rd_data),
        .wr_en   (lk_we),
        .wr_addr (lk_waddr),
        .wr_data (lk_wr_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign in_q_ok  = (32'(s_queue_id) < QUEUES);
    assign in_e_ok  = (32'(s_entry_index) < ENTRIES);
    assign in_op_ok = (s_operation == mqll_pkg::OP_APPEND) ||
                      (s_operation == mqll_pkg::OP_POP) ||
                      (s_operation == mqll_pkg::OP_REMOVE);
    assign in_bad   = !in_q_ok || !in_op_ok ||
                      ((s_operation != mqll_pkg::OP_POP) && !in_e_ok);

    assign qt_empty = (qt_rd_head >= NIL);
    assign lk_nil   = (lk_rd_data >= NIL);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        hd_next    = hd_reg;
        tl_next    = tl_reg;
        pred_next  = pred_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;

        fin        = 1'b0;
        fin_status = mqll_pkg::STATUS_FAIL;
        fin_popped = '0;

        qt_re      = 1'b0;
        qt_raddr   = q_reg;
        qt_we      = 1'b0;
        qt_waddr   = q_reg;
        qt_wr_head = NIL;
        qt_wr_tail = NIL;
        lk_re      = 1'b0;
        lk_raddr   = hd_reg[IW-1:0];
        lk_we      = 1'b0;
        lk_waddr   = e_reg[IW-1:0];
        lk_wr_data = NIL;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next = mqll_pkg::op_t'(s_operation);
                    q_next  = QW'(s_queue_id);
                    e_next  = LW'(s_entry_index);
                    if (in_bad) begin
                        // Drop the item with a fail status, state untouched.
                        fin = 1'b1;
                    end else begin
                        qt_re      = 1'b1;
                        qt_raddr   = QW'(s_queue_id);
                        state_next = S_QRD;
                    end
                end
            end

            S_QRD: begin
                hd_next = qt_rd_head;
                tl_next = qt_rd_tail;
                unique case (op_reg) inside
                    mqll_pkg::OP_APPEND: begin
                        qt_we      = 1'b1;
                        qt_wr_tail = e_reg;
                        if (qt_empty) begin
                            qt_wr_head = e_reg;
                            lk_we      = 1'b1;
                            lk_waddr   = e_reg[IW-1:0];
                            lk_wr_data = NIL;
                            fin        = 1'b1;
                            fin_status = mqll_pkg::STATUS_OK;
                        end else begin
                            qt_wr_head = qt_rd_head;
                            if (qt_rd_tail < NIL) begin
                                lk_we      = 1'b1;
                                lk_waddr   = qt_rd_tail[IW-1:0];
                                lk_wr_data = e_reg;
                            end
                            state_next = S_APP2;
                        end
                    end
                    mqll_pkg::OP_POP, mqll_pkg::OP_REMOVE: begin
                        if (qt_empty) begin
                            fin = 1'b1;
                        end else begin
                            lk_re    = 1'b1;
                            lk_raddr = qt_rd_head[IW-1:0];
                            if (op_reg == mqll_pkg::OP_POP || qt_rd_head == e_reg) begin
                                cur_next   = qt_rd_head;
                                state_next = S_POPW;
                            end else begin
                                pred_next  = qt_rd_head;
                                steps_next = '0;
                                state_next = S_WALK;
                            end
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_APP2: begin
                lk_we      = 1'b1;
                lk_waddr   = e_reg[IW-1:0];
                lk_wr_data = NIL;
                fin        = 1'b1;
                fin_status = mqll_pkg::STATUS_OK;
            end

            S_POPW: begin
                // Advance the head; an empty list loses its tail too.
                qt_we = 1'b1;
                if (lk_nil) begin
                    qt_wr_head = NIL;
                    qt_wr_tail = NIL;
                end else begin
                    qt_wr_head = lk_rd_data;
                    qt_wr_tail = tl_reg;
                end
                lk_we      = 1'b1;
                lk_waddr   = cur_reg[IW-1:0];
                lk_wr_data = NIL;
                fin        = 1'b1;
                fin_status = mqll_pkg::STATUS_OK;
                if (op_reg == mqll_pkg::OP_POP) begin
                    fin_popped = mqll_pkg::ENT_W'(cur_reg);
                end
            end

            S_WALK: begin
                if (lk_nil) begin
                    fin = 1'b1;
                end else if (lk_rd_data == e_reg) begin
                    lk_re      = 1'b1;
                    lk_raddr   = lk_rd_data[IW-1:0];
                    cur_next   = lk_rd_data;
                    state_next = S_RM;
                end else if (steps_reg == LAST_STEP) begin
                    // Bounded walk: give up after one link per slot.
                    fin = 1'b1;
                end else begin
                    lk_re      = 1'b1;
                    lk_raddr   = lk_rd_data[IW-1:0];
                    pred_next  = lk_rd_data;
                    steps_next = steps_reg + 1'b1;
                end
            end

            S_RM: begin
                lk_we      = 1'b1;
                lk_waddr   = pred_reg[IW-1:0];
                lk_wr_data = lk_rd_data;
                if (tl_reg == cur_reg) begin
                    qt_we      = 1'b1;
                    qt_wr_head = hd_reg;
                    qt_wr_tail = pred_reg;
                end
                state_next = S_RM2;
            end

            S_RM2: begin
                lk_we      = 1'b1;
                lk_waddr   = cur_reg[IW-1:0];
                lk_wr_data = NIL;
                fin        = 1'b1;
                fin_status = mqll_pkg::STATUS_OK;
            end

            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            state_next = out_free ? S_IDLE : S_DONE;
        end
    end

    // Load the output register from a fresh result or from the parked one.
    assign out_load = out_free && (fin || (state_reg == S_DONE));

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        q_reg     <= q_next;
        e_reg     <= e_next;
        hd_reg    <= hd_next;
        tl_reg    <= tl_next;
        pred_reg  <= pred_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        if (fin) begin
            res_status_reg <= fin_status;
            res_popped_reg <= fin_popped;
        end
        if (out_load) begin
            m_status_reg <= fin ? fin_status : res_status_reg;
            m_popped_reg <= fin ? fin_popped : res_popped_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_entry = m_popped_reg;

`ifndef ASSERT_OFF
    a_fail_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == mqll_pkg::STATUS_FAIL) |-> (m_popped_reg == '0))
        else $error("failed item carries a popped slot");

    a_idle_no_link_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !lk_we)
        else $error("link memory written while idle");

    a_walk_pred_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK || state_reg == S_RM) |-> (pred_reg < NIL))
        else $error("walk predecessor is nil");

    a_link_single_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(lk_re && lk_we))
        else $error("link memory read and written in one cycle");

    a_done_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> m_valid_reg)
        else $error("parked result with empty output register");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mqll_link_mem.sv =====
`default_nettype none

// Next-link store: one write port, one read port, registered read data.
module mqll_link_mem #(
    parameter int ENTRIES = mqll_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES),
    localparam int LW = $clog2(ENTRIES + 1)
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [LW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [LW-1:0] wr_data
);

    logic [LW-1:0] link_mem [ENTRIES];
    logic [LW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mqll_queue_mem.sv =====
`default_nettype none

// Head/tail table. A queue never written since reset reads as empty (both nil).
module mqll_queue_mem #(
    parameter int QUEUES  = mqll_pkg::QUEUES_DEF,
    parameter int ENTRIES = mqll_pkg::ENTRIES_DEF,
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1,
    localparam int LW = $clog2(ENTRIES + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [QW-1:0] rd_addr,
    output logic      [LW-1:0] rd_head,
    output logic      [LW-1:0] rd_tail,
    input  wire logic          wr_en,
    input  wire logic [QW-1:0] wr_addr,
    input  wire logic [LW-1:0] wr_head,
    input  wire logic [LW-1:0] wr_tail
);

    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    logic [2*LW-1:0] qt_mem [QUEUES];
    logic [2*LW-1:0] rd_data_reg;
    logic [QUEUES-1:0] valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            qt_mem[wr_addr] <= {wr_head, wr_tail};
        end
        if (rd_en) begin
            rd_data_reg <= qt_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_head = rd_valid_reg ? rd_data_reg[2*LW-1:LW] : NIL;
    assign rd_tail = rd_valid_reg ? rd_data_reg[LW-1:0]    : NIL;

endmodule

`default_nettype wire
